// File: hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg - shared types and constants for the radix digit converter
// Command and status structs between controller and datapath, field widths,
// character codes and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  localparam int COUNT_W   = 5;
  localparam int STEP_BITS = 8;  // dividend bits consumed per divide cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture value and radix, clear counters
    logic step;      // run a divide cycle
    logic commit;    // last divide cycle of a digit: store it
    logic ptr_dec;   // advance read pointer toward the least significant digit
    logic emit;      // a digit result is on the outputs
    logic emit_err;  // the error result is on the outputs
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic radix_ok;   // radix at the input is in 2..16
    logic div_done;   // next quotient is zero or this digit fills the digit store
    logic emit_last;  // digit on the outputs is the final one
  } dp_stat_t;

  function automatic logic radix_valid(input logic [RADIX_W-1:0] r);
    radix_valid = r inside {[RADIX_MIN:RADIX_MAX]};
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    if (d < DEC_LIMIT) begin
      ascii_of = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ascii_of = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
  endfunction

endpackage

// File: hdl/rdc_ram.sv
// ----------------------------------------------------------------------------
// rdc_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl - conversion sequencer, with an error result for a bad radix
// Accepts a request, runs the divide cycles for each digit, then walks the
// digit store from the most significant digit and marks each result.
// ----------------------------------------------------------------------------
module rdc_ctrl #(
  parameter int STEPS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               strobe,
  input  rdc_pkg::dp_stat_t  stat,
  output rdc_pkg::ctrl_cmd_t cmd
);
  import rdc_pkg::*;

  localparam int SCW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [SCW-1:0] STEP_LAST = SCW'(STEPS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ERR  = 5'b10000
  } state_t;

  state_t         state, state_next;
  logic [SCW-1:0] step_cnt, step_cnt_next;

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        step_cnt_next = '0;
        if (start) begin
          if (stat.radix_ok) begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_LAST) begin
          cmd.commit    = 1'b1;
          step_cnt_next = '0;
          if (stat.div_done) begin
            state_next = ST_READ;
          end
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_READ: begin
        cmd.ptr_dec = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.ptr_dec = 1'b1;
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        cmd.emit_err = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign strobe = cmd.emit | cmd.emit_err;

endmodule

// File: hdl/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath - divider, digit store and result fields
// Long division by the radix, eight dividend bits per cycle, with the
// remainder of each division written to the digit store.
// ----------------------------------------------------------------------------
module rdc_datapath #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [VALUE_BITS-1:0]           value,
  input  logic [rdc_pkg::RADIX_W-1:0]     radix,
  input  rdc_pkg::ctrl_cmd_t              cmd,
  output rdc_pkg::dp_stat_t               stat,
  output logic [rdc_pkg::DIGIT_W-1:0]     digit,
  output logic [rdc_pkg::CHAR_W-1:0]      digit_char,
  output logic [rdc_pkg::COUNT_W-1:0]     digit_count,
  output logic                            bad_radix,
  output logic                            last
);
  import rdc_pkg::*;

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int W     = STEPS * STEP_BITS;
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_DIGITS - 1);

  logic [W-1:0]       quo;        // remaining quotient, shifted through
  logic [W-1:0]       quo_next;
  logic [RADIX_W-1:0] rem;        // partial remainder, always below radix
  logic [RADIX_W-1:0] rem_next;
  logic [RADIX_W-1:0] rdx;
  logic [CW-1:0]      count;
  logic [CW-1:0]      emit_idx;
  logic [AW-1:0]      rd_ptr;
  logic [DIGIT_W-1:0] rd_data;

  // Each divide cycle: eight restoring steps on the narrow remainder
  always_comb begin
    logic [RADIX_W-1:0]   r;
    logic [STEP_BITS-1:0] bits;
    logic [STEP_BITS-1:0] qbits;
    r     = rem;
    bits  = quo[W-1 -: STEP_BITS];
    qbits = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = {r[RADIX_W-2:0], bits[i]};
      if (r >= rdx) begin
        r        = r - rdx;
        qbits[i] = 1'b1;
      end
    end
    rem_next = r;
    // Shift the consumed byte out and the quotient bits in
    quo_next = W'({quo, qbits});
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quo <= '0;
      rem <= '0;
    end else if (cmd.load) begin
      quo <= W'(value);
      rem <= '0;
    end else if (cmd.step) begin
      quo <= quo_next;
      rem <= cmd.commit ? '0 : rem_next;
    end
  end

  // Radix latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdx <= radix;
    end
  end

  // Digit count, emit index and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      emit_idx <= '0;
      rd_ptr   <= '0;
    end else begin
      if (cmd.load) begin
        count    <= '0;
        emit_idx <= '0;
      end else begin
        if (cmd.commit) begin
          count <= count + 1'b1;
        end
        if (cmd.emit) begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
      if (cmd.commit) begin
        rd_ptr <= count[AW-1:0];
      end else if (cmd.ptr_dec) begin
        rd_ptr <= rd_ptr - 1'b1;
      end
    end
  end

  // Digit store, least significant digit at entry zero
  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count[AW-1:0]),
    .wdata (rem_next[DIGIT_W-1:0]),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // Status to the controller
  assign stat.radix_ok  = radix_valid(radix);
  assign stat.div_done  = (quo_next == '0) || (count == COUNT_FULL);
  assign stat.emit_last = (emit_idx == count - 1'b1);

  // Result fields; the error result carries zeros in digit, digit_char and digit_count
  always_comb begin
    if (cmd.emit_err) begin
      digit       = '0;
      digit_char  = '0;
      digit_count = '0;
      bad_radix   = 1'b1;
      last        = 1'b1;
    end else begin
      digit       = rd_data;
      digit_char  = ascii_of(rd_data);
      digit_count = COUNT_W'(count);
      bad_radix   = 1'b0;
      last        = stat.emit_last;
    end
  end

endmodule

// File: hdl/radix_digit_converter_core.sv
// A bad radix gives its single result in the cycle after the request.
// Otherwise the 8-bit-per-cycle long divider runs the divide cycles of each
// digit, then a read state fetches the most significant digit and the emit
// state strobes out the digits, most significant first.
// One request at a time; busy is high until the last result. The receiver
// cannot stall. Synchronous reset returns to idle with an empty digit count.
// ----------------------------------------------------------------------------
// radix_digit_converter_core - integer to radix 2..16 digit converter
// Converts by repeated division, then emits digits most significant first.
// ----------------------------------------------------------------------------
module radix_digit_converter_core #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_BITS-1:0]       value,
  input  logic [rdc_pkg::RADIX_W-1:0] radix,
  output logic                        strobe,
  output logic [rdc_pkg::DIGIT_W-1:0] digit,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
  output logic [rdc_pkg::COUNT_W-1:0] digit_count,
  output logic                        bad_radix,
  output logic                        last
);
  import rdc_pkg::*;

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  rdc_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .stat   (stat),
    .cmd    (cmd)
  );

  // Divider and digit store
  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .radix       (radix),
    .cmd         (cmd),
    .stat        (stat),
    .digit       (digit),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .bad_radix   (bad_radix),
    .last        (last)
  );

endmodule

// File: dv/radix_digit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_checker - digit stream predictor and comparator
// Watches the request and result channels of the radix digit converter.
// Predicts the digit results for each accepted request by repeated division,
// then compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module radix_digit_checker #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [VALUE_BITS-1:0]       value,
  input  logic [rdc_pkg::RADIX_W-1:0] radix,
  input  logic                        strobe,
  input  logic [rdc_pkg::DIGIT_W-1:0] digit,
  input  logic [rdc_pkg::CHAR_W-1:0]  digit_char,
  input  logic [rdc_pkg::COUNT_W-1:0] digit_count,
  input  logic                        bad_radix,
  input  logic                        last,
  output int                          errors,
  output int                          outstanding
);

  import rdc_pkg::*;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  glyph;
    logic [COUNT_W-1:0] count;
    logic               bad;
    logic               last;
  } digit_result_t;

  // Digits still owed by the block, oldest first
  digit_result_t pending_digits[$];

  string glyph_table = "0123456789ABCDEF";
  int    result_index;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on result %0d: %s got %0h, want %0h",
             $realtime, result_index, what, got, want);
    errors++;
  endtask

  // Queue an error result for a bad radix; else divide repeatedly, then queue the remainders most significant first
  function automatic void expand_digits(input logic [VALUE_BITS-1:0] v,
                                        input logic [RADIX_W-1:0] r);
    logic [DIGIT_W-1:0]    rems[MAX_DIGITS];
    logic [VALUE_BITS-1:0] quot;
    int                    n;
    digit_result_t         res;
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      res      = '0;
      res.bad  = 1'b1;
      res.last = 1'b1;
      pending_digits.push_back(res);
      return;
    end
    quot = v;
    n    = 0;
    if (quot == '0) begin
      rems[0] = '0;
      n       = 1;
    end else begin
      while (quot != '0 && n < MAX_DIGITS) begin
        rems[n] = DIGIT_W'(quot % VALUE_BITS'(r));
        quot    = quot / VALUE_BITS'(r);
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      res.digit = rems[k];
      res.glyph = CHAR_W'(glyph_table[rems[k]]);
      res.count = COUNT_W'(n);
      res.bad   = 1'b0;
      res.last  = (k == 0);
      pending_digits.push_back(res);
    end
  endfunction

  // Check results, then predict new requests, once per clock edge
  always @(posedge clk) begin
    digit_result_t want;
    if (rst) begin
      pending_digits.delete();
      result_index = 0;
    end else begin
      if (strobe) begin
        if (pending_digits.size() == 0) begin
          report_mismatch("unexpected strobe, digit", 32'(digit), 32'h0);
        end else begin
          want = pending_digits.pop_front();
          if (digit !== want.digit)
            report_mismatch("digit", 32'(digit), 32'(want.digit));
          if (digit_char !== want.glyph)
            report_mismatch("digit_char", 32'(digit_char), 32'(want.glyph));
          if (digit_count !== want.count)
            report_mismatch("digit_count", 32'(digit_count), 32'(want.count));
          if (bad_radix !== want.bad)
            report_mismatch("bad_radix", 32'(bad_radix), 32'(want.bad));
          if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
        end
        result_index++;
      end
      if (start && !busy) begin
        expand_digits(value, radix);
      end
    end
    outstanding <= pending_digits.size();
  end

endmodule

// File: dv/tb_radix_digit_converter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter_core - testbench for the radix digit converter
// Drives directed corner requests and then random requests with random gaps
// between them; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter_core;

  import rdc_pkg::*;

  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 31;
  localparam int RANDOM_REQUESTS = 170;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] value = '0;
  logic [RADIX_W-1:0]    radix = '0;
  logic                  strobe;
  logic [DIGIT_W-1:0]    digit;
  logic [CHAR_W-1:0]     digit_char;
  logic [COUNT_W-1:0]    digit_count;
  logic                  bad_radix;
  logic                  last;
  int                    errors;
  int                    outstanding;
  logic                  burst_mode = 1'b0;

  radix_digit_converter_core #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .radix       (radix),
    .strobe      (strobe),
    .digit       (digit),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .bad_radix   (bad_radix),
    .last        (last)
  );

  radix_digit_checker #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .radix       (radix),
    .strobe      (strobe),
    .digit       (digit),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .bad_radix   (bad_radix),
    .last        (last),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Drop start for a random gap (none in burst mode), hold it until busy falls
  task automatic send_request(input logic [VALUE_BITS-1:0] v,
                              input logic [RADIX_W-1:0] r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    radix <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_W-1:0]    r;
    longint                power;
    int                    pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, all-ones in every valid radix, bad radices, all letters
    send_request('0, RADIX_MIN);
    send_request('0, RADIX_MAX);
    for (int rr = 2; rr <= 16; rr++) begin
      send_request({VALUE_BITS{1'b1}}, RADIX_W'(rr));
    end
    send_request(VALUE_BITS'(1), RADIX_MIN);
    send_request(VALUE_BITS'(32'h7FED_CBA9), RADIX_MAX);
    send_request({VALUE_BITS{1'b1}}, RADIX_W'(0));
    send_request(VALUE_BITS'(1234), RADIX_W'(1));
    send_request('0, RADIX_W'(17));
    send_request({VALUE_BITS{1'b1}}, RADIX_W'(31));

    // Random: mostly valid radices with values shaped around digit boundaries
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 16 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        r = RADIX_W'($urandom_range(2, 16));
      end else begin
        pick = $urandom_range(0, 16);
        r    = RADIX_W'(pick < 2 ? pick : pick + 15);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = VALUE_BITS'($urandom);
        4:          v = '0;
        5:          v = VALUE_BITS'($urandom_range(0, 255));
        6:          v = {VALUE_BITS{1'b1}} - VALUE_BITS'($urandom_range(0, 15));
        7: begin
          // land on or just below a power of the radix
          power = 1;
          repeat ($urandom_range(1, 30)) begin
            if (r >= 2 && power * r < (64'd1 << VALUE_BITS)) power = power * r;
          end
          v = VALUE_BITS'(power - $urandom_range(0, 1));
        end
        default:    v = VALUE_BITS'($urandom >> $urandom_range(0, 31));
      endcase
      send_request(v, r);
    end
    start <= 1'b0;

    // Drain the expected digits, then watch for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("** radix_digit_converter_core: PASSED **");
    end else begin
      $display("** radix_digit_converter_core: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("timeout with %0d digits outstanding", outstanding);
    $display("** radix_digit_converter_core: FAILED **");
    $finish;
  end

endmodule
